FILE: src/rdpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_pkg
// Shared types, characters and beat codes of the remote-debug packet framer.
// ----------------------------------------------------------------------------
package rdpf_pkg;

    localparam int MAX_FRAME_BITS = 13;
    localparam int CFG_WIDTH      = 13;
    localparam int MAX_LEN_RESET  = 2048;
    localparam int QUEUE_DEPTH    = 2;
    localparam int TRAILER_LEN    = 3;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ESC   = 8'h7D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] ESC_XOR  = 8'h20;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_ESC   = 3'd1;
    localparam logic [2:0] K_BYTE  = 3'd2;
    localparam logic [2:0] K_HASH  = 3'd3;
    localparam logic [2:0] K_HI    = 3'd4;
    localparam logic [2:0] K_LO    = 3'd5;
    localparam logic [2:0] K_OVF   = 3'd6;

    typedef struct packed {
        logic       start;
        logic       esc;
        logic       trailer;
        logic       ovf;
        logic [7:0] data;
        logic [7:0] sum;
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] n8;
        n8 = {4'h0, nib};
        if (nib < 4'd10) begin
            hex_char = n8 + 8'h30;
        end else begin
            hex_char = n8 + 8'h57;
        end
    endfunction

endpackage

FILE: src/rdpf_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_item_if
// Input channel: one payload byte per beat with its escape and last flags.
// ----------------------------------------------------------------------------
interface rdpf_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       escape_enable;
    logic       last;

    modport source (output valid, output data_byte, output escape_enable, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input escape_enable, input last,
                    output ready);
endinterface

FILE: src/rdpf_beat_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_beat_if
// Output channel: one framed link byte per beat with its end and status flags.
// ----------------------------------------------------------------------------
interface rdpf_beat_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;
    logic       frame_end;
    logic       overflow;

    modport source (output valid, output out_byte, output run_end, output frame_end,
                    output overflow, input ready);
    modport sink   (input valid, input out_byte, input run_end, input frame_end,
                    input overflow, output ready);
endinterface

FILE: src/rdpf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_queue
// Short job queue between the classifier and the beat sequencer.
// ----------------------------------------------------------------------------
module rdpf_queue #(
    parameter int DEPTH = rdpf_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rdpf_pkg::t_job i_data,
    output logic           o_full,
    output logic           o_valid,
    output rdpf_pkg::t_job o_data,
    input  logic           i_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rdpf_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

endmodule

FILE: src/rdpf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_front
// Accept payload beats, run the room check and checksum, and emit one job each.
// ----------------------------------------------------------------------------
module rdpf_front #(
    parameter int MAX_FRAME_BITS = rdpf_pkg::MAX_FRAME_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rdpf_pkg::CFG_WIDTH-1:0]    i_cfg_wdata,
    rdpf_item_if.sink                         i_in,
    output logic                              o_push,
    output rdpf_pkg::t_job                    o_job,
    input  logic                              i_full
);
    localparam int W  = MAX_FRAME_BITS;
    localparam int CW = MAX_FRAME_BITS + 1;
    localparam logic [W-1:0] LEN_RESET = W'(rdpf_pkg::MAX_LEN_RESET);

    logic [W-1:0] r_max_len;
    logic         r_in_packet;
    logic [7:0]   r_sum;
    logic [W-1:0] r_bytes;
    logic         r_ovf;

    logic         special;
    logic [1:0]   need;
    logic [CW-1:0] total;
    logic         over;
    logic         ovf_now;
    logic [7:0]   esc_byte;
    logic [7:0]   add_val;
    logic [7:0]   n_sum;
    logic [W-1:0] n_bytes;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        special = i_in.escape_enable && (i_in.data_byte == rdpf_pkg::CH_START ||
                  i_in.data_byte == rdpf_pkg::CH_END || i_in.data_byte == rdpf_pkg::CH_ESC ||
                  i_in.data_byte == rdpf_pkg::CH_STAR);
        need     = (special ? 2'd2 : 2'd1) + (r_in_packet ? 2'd0 : 2'd1);
        total    = CW'(r_bytes) + CW'(need) + CW'(rdpf_pkg::TRAILER_LEN);
        over     = (total > CW'(r_max_len));
        ovf_now  = r_ovf || over;
        esc_byte = special ? (i_in.data_byte ^ rdpf_pkg::ESC_XOR) : i_in.data_byte;
        add_val  = special ? (rdpf_pkg::CH_ESC + esc_byte) : i_in.data_byte;
        n_sum    = (r_in_packet ? r_sum : 8'h00) + add_val;
        n_bytes  = (r_in_packet ? r_bytes : W'(1)) + (special ? W'(2) : W'(1));

        o_job.start   = !ovf_now && !r_in_packet;
        o_job.esc     = !ovf_now && special;
        o_job.trailer = !ovf_now && i_in.last;
        o_job.ovf     = ovf_now;
        o_job.data    = esc_byte;
        o_job.sum     = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= W'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_sum       <= '0;
            r_bytes     <= '0;
            r_ovf       <= 1'b0;
        end else if (o_push) begin
            if (i_in.last) begin
                r_in_packet <= 1'b0;
                r_sum       <= '0;
                r_bytes     <= '0;
                r_ovf       <= 1'b0;
            end else if (ovf_now) begin
                r_ovf <= 1'b1;
            end else begin
                r_in_packet <= 1'b1;
                r_sum       <= n_sum;
                r_bytes     <= n_bytes;
            end
        end
    end

endmodule

FILE: src/rdpf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpf_back
// Expand each job into its link bytes, one beat per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rdpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  rdpf_pkg::t_job i_q_job,
    output logic           o_pop,
    rdpf_beat_if.source    o_out
);
    logic           r_busy;
    logic [2:0]     r_kind;
    rdpf_pkg::t_job r_job;

    logic       last_beat;
    logic       fire;
    logic       take;
    logic [2:0] next_kind;
    logic [2:0] first_kind;

    always_comb begin
        last_beat = 1'b0;
        next_kind = rdpf_pkg::K_BYTE;
        case (r_kind)
            rdpf_pkg::K_START: next_kind = r_job.esc ? rdpf_pkg::K_ESC : rdpf_pkg::K_BYTE;
            rdpf_pkg::K_ESC:   next_kind = rdpf_pkg::K_BYTE;
            rdpf_pkg::K_BYTE: begin
                next_kind = rdpf_pkg::K_HASH;
                last_beat = !r_job.trailer;
            end
            rdpf_pkg::K_HASH:  next_kind = rdpf_pkg::K_HI;
            rdpf_pkg::K_HI:    next_kind = rdpf_pkg::K_LO;
            rdpf_pkg::K_LO:    last_beat = 1'b1;
            rdpf_pkg::K_OVF:   last_beat = 1'b1;
            default:           last_beat = 1'b1;
        endcase

        if (i_q_job.ovf) begin
            first_kind = rdpf_pkg::K_OVF;
        end else if (i_q_job.start) begin
            first_kind = rdpf_pkg::K_START;
        end else if (i_q_job.esc) begin
            first_kind = rdpf_pkg::K_ESC;
        end else begin
            first_kind = rdpf_pkg::K_BYTE;
        end
    end

    assign fire  = o_out.valid && o_out.ready;
    assign take  = !r_busy || (fire && last_beat);
    assign o_pop = take && i_q_valid;

    always_comb begin
        o_out.valid     = r_busy;
        o_out.run_end   = last_beat;
        o_out.frame_end = 1'b0;
        o_out.overflow  = 1'b0;
        o_out.out_byte  = 8'h00;
        case (r_kind)
            rdpf_pkg::K_START: o_out.out_byte = rdpf_pkg::CH_START;
            rdpf_pkg::K_ESC:   o_out.out_byte = rdpf_pkg::CH_ESC;
            rdpf_pkg::K_BYTE:  o_out.out_byte = r_job.data;
            rdpf_pkg::K_HASH:  o_out.out_byte = rdpf_pkg::CH_END;
            rdpf_pkg::K_HI:    o_out.out_byte = rdpf_pkg::hex_char(r_job.sum[7:4]);
            rdpf_pkg::K_LO: begin
                o_out.out_byte  = rdpf_pkg::hex_char(r_job.sum[3:0]);
                o_out.frame_end = 1'b1;
            end
            rdpf_pkg::K_OVF:   o_out.overflow = 1'b1;
            default:           o_out.out_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_kind <= rdpf_pkg::K_BYTE;
        end else if (take) begin
            r_busy <= i_q_valid;
            r_kind <= first_kind;
        end else if (fire) begin
            r_kind <= next_kind;
        end
    end

`ifndef ASSERT_OFF
    a_frame_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.frame_end |-> o_out.run_end)
        else $error("frame end without run end");

    a_ovf_beat_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |->
            o_out.out_byte == 8'h00 && o_out.run_end && !o_out.frame_end)
        else $error("malformed overflow beat");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !o_out.ready |=> r_busy && $stable(r_kind))
        else $error("sequencer advanced while stalled");

    a_hash_before_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_kind == rdpf_pkg::K_HASH |=> r_busy && r_kind == rdpf_pkg::K_HI)
        else $error("checksum digit did not follow hash");
`endif

endmodule

FILE: src/remote_debug_packet_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_debug_packet_framer_core
// Frames payload bytes into remote-debug packets with escaping and checksum.
//
// i_in carries one payload byte per beat with escape_enable and last. o_out
// carries one link byte per beat; run_end marks the final byte caused by an
// input beat, frame_end the second checksum digit, overflow an abandoned
// packet. i_cfg_we / i_cfg_wdata write max_frame_len; write only when idle.
// Each input beat yields 1 to 6 output beats ('$', '}', byte, '#', hi, lo).
// Flow: an input beat is written to the job queue and then loaded into the
// output sequencer, which presents the first output byte. The sequencer
// sends one output byte per cycle while the receiver is ready. A job queue
// of QUEUE_DEPTH entries lets input keep arriving while output bytes are
// still going out. Reset (synchronous, active low) closes any open packet,
// empties the queue and loads max_frame_len with 2048. A stalled receiver
// holds the current byte; input is refused once the queue fills.
// ----------------------------------------------------------------------------
module remote_debug_packet_framer_core #(
    parameter int MAX_FRAME_BITS = rdpf_pkg::MAX_FRAME_BITS,
    parameter int QUEUE_DEPTH    = rdpf_pkg::QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rdpf_pkg::CFG_WIDTH-1:0] i_cfg_wdata,
    rdpf_item_if.sink                      i_in,
    rdpf_beat_if.source                    o_out
);
    logic           push;
    logic           full;
    logic           q_valid;
    logic           pop;
    rdpf_pkg::t_job front_job;
    rdpf_pkg::t_job q_job;

    rdpf_front #(
        .MAX_FRAME_BITS (MAX_FRAME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_push      (push),
        .o_job       (front_job),
        .i_full      (full)
    );

    rdpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_job),
        .i_pop   (pop)
    );

    rdpf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: test/remote_debug_packet_framer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remote_debug_packet_framer_core_test
// Self-checking bench for the remote-debug packet framer.
//
// Payload beats go in through a bursty sender, and link bytes come out
// against a receiver that stalls on a pattern of its own. The bench keeps
// its own model of the framing, with start character, escaping, running
// sum, hex trailer and the frame-length limit. It checks every link byte in
// order against that model. Directed tests cover byte extremes, escaping
// on and off, overflow with and without escaping, and tiny limits. Random
// packets then run under a range of max_frame_len settings.
// ----------------------------------------------------------------------------
module remote_debug_packet_framer_core_test;

    localparam int CFG_W    = rdpf_pkg::CFG_WIDTH;
    localparam int LEN_BITS = rdpf_pkg::MAX_FRAME_BITS;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
        logic       frame_end;
        logic       overflow;
    } t_link_beat;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] SPECIALS [4] = '{rdpf_pkg::CH_START, rdpf_pkg::CH_END,
                                            rdpf_pkg::CH_ESC, rdpf_pkg::CH_STAR};
    localparam int DRAIN_LIMIT = 20000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    rdpf_item_if in_if ();
    rdpf_beat_if out_if ();

    remote_debug_packet_framer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    // framing model state
    logic [CFG_W-1:0]    max_len   = CFG_W'(rdpf_pkg::MAX_LEN_RESET);
    logic                open_pkt  = 1'b0;
    logic [7:0]          run_sum   = 8'h00;
    logic [LEN_BITS-1:0] sent_len  = '0;
    logic                abandoned = 1'b0;

    t_link_beat pending_beats[$];
    t_link_beat head_beat;

    int errors         = 0;
    int mismatches     = 0;
    int items_sent     = 0;
    int packets_sent   = 0;
    int bytes_checked  = 0;
    int overflow_beats = 0;
    int frames_closed  = 0;
    int settings_used  = 1;
    int burst_left     = 4;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("** remote_debug_packet_framer_core: FAILED **");
        $finish;
    end

    task automatic clear_packet_state();
        open_pkt  = 1'b0;
        run_sum   = 8'h00;
        sent_len  = '0;
        abandoned = 1'b0;
    endtask

    task automatic predict_framing(input logic [7:0] b, input logic esc, input logic lst);
        t_link_beat beats [6];
        int         n;
        int         need;
        logic       special;
        logic [7:0] body [2];
        int         nbody;
        n = 0;
        special = esc && (b == rdpf_pkg::CH_START || b == rdpf_pkg::CH_END ||
                          b == rdpf_pkg::CH_ESC || b == rdpf_pkg::CH_STAR);
        need = (special ? 2 : 1) + (open_pkt ? 0 : 1);
        if (!abandoned && int'(sent_len) + need + rdpf_pkg::TRAILER_LEN > int'(max_len)) begin
            abandoned = 1'b1;
        end
        if (abandoned) begin
            beats[0] = '{8'h00, 1'b0, 1'b0, 1'b1};
            n = 1;
            overflow_beats++;
            if (lst) begin
                clear_packet_state();
            end
        end else begin
            if (!open_pkt) begin
                beats[n] = '{rdpf_pkg::CH_START, 1'b0, 1'b0, 1'b0};
                n++;
                open_pkt = 1'b1;
                run_sum  = 8'h00;
                sent_len = LEN_BITS'(1);
            end
            if (special) begin
                body[0] = rdpf_pkg::CH_ESC;
                body[1] = b ^ rdpf_pkg::ESC_XOR;
                nbody = 2;
            end else begin
                body[0] = b;
                nbody = 1;
            end
            for (int k = 0; k < nbody; k++) begin
                beats[n] = '{body[k], 1'b0, 1'b0, 1'b0};
                n++;
                run_sum  = run_sum + body[k];
                sent_len = sent_len + 1'b1;
            end
            if (lst) begin
                beats[n]     = '{rdpf_pkg::CH_END, 1'b0, 1'b0, 1'b0};
                beats[n + 1] = '{HEX_DIGITS[run_sum[7:4]], 1'b0, 1'b0, 1'b0};
                beats[n + 2] = '{HEX_DIGITS[run_sum[3:0]], 1'b0, 1'b1, 1'b0};
                n += 3;
                frames_closed++;
                clear_packet_state();
            end
        end
        beats[n - 1].run_end = 1'b1;
        for (int k = 0; k < n; k++) begin
            pending_beats.push_back(beats[k]);
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic esc, input logic lst);
        in_if.valid         <= 1'b1;
        in_if.data_byte     <= b;
        in_if.escape_enable <= esc;
        in_if.last          <= lst;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_framing(b, esc, lst);
        items_sent++;
        if (lst) packets_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            in_if.valid <= 1'b0;
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(6, 20)) @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        if (pending_beats.size() != 0) begin
            $display("ERROR: %0d expected link bytes never arrived", pending_beats.size());
            errors += pending_beats.size();
            pending_beats.delete();
        end
    endtask

    task automatic write_max_len(input logic [CFG_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        max_len = value;
        settings_used++;
        @(posedge i_clk);
    endtask

    task automatic send_packet(input int len, input int esc_mode);
        logic [7:0] b;
        logic       esc;
        for (int k = 0; k < len; k++) begin
            b = ($urandom_range(0, 3) == 0) ? SPECIALS[$urandom_range(0, 3)]
                                            : 8'($urandom_range(0, 255));
            esc = (esc_mode == 2) ? 1'($urandom_range(0, 1)) : esc_mode[0];
            send_beat(b, esc, k == len - 1);
        end
    endtask

    task automatic test_single_byte_packets();
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h55, 1'b1, 1'b1);
    endtask

    task automatic test_escaping();
        send_beat(rdpf_pkg::CH_START, 1'b1, 1'b0);
        send_beat(rdpf_pkg::CH_END, 1'b1, 1'b0);
        send_beat(rdpf_pkg::CH_ESC, 1'b1, 1'b0);
        send_beat(rdpf_pkg::CH_STAR, 1'b1, 1'b0);
        send_beat(rdpf_pkg::CH_START, 1'b0, 1'b0);
        send_beat(rdpf_pkg::CH_STAR, 1'b0, 1'b1);
    endtask

    task automatic test_overflow();
        write_max_len(CFG_W'(8));
        send_beat(8'h01, 1'b0, 1'b0);
        send_beat(8'h80, 1'b0, 1'b0);
        send_beat(8'hFE, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b0, 1'b0);
        send_beat(8'h10, 1'b0, 1'b0);
        send_beat(8'h20, 1'b0, 1'b1);
        // escaped byte overflows where a plain one would fit, and is last itself
        send_beat(8'hA5, 1'b0, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'h33, 1'b0, 1'b0);
        send_beat(rdpf_pkg::CH_ESC, 1'b1, 1'b1);
    endtask

    task automatic test_tiny_limits();
        write_max_len(CFG_W'(3));
        send_beat(8'hC3, 1'b0, 1'b1);
        write_max_len(CFG_W'(0));
        send_beat(rdpf_pkg::CH_END, 1'b1, 1'b0);
        send_beat(8'h3C, 1'b0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int limits [9] = '{8, 20, 8191, 37, 4096, 3, 13, 0, 2048};
        int start_items;
        int len;
        for (int p = 0; p < 9; p++) begin
            write_max_len(CFG_W'(limits[p]));
            start_items = items_sent;
            while (items_sent - start_items < 36) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
                send_packet(len, $urandom_range(0, 2));
                if (p == 4 && items_sent - start_items >= 20
                        && items_sent - start_items - len < 20) begin
                    wait_drained();
                end
            end
        end
    endtask

    initial begin
        out_if.ready <= 1'b1;
        forever begin
            int mode;
            int span;
            mode = $urandom_range(0, 3);
            span = $urandom_range(30, 120);
            for (int c = 0; c < span; c++) begin
                @(posedge i_clk);
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= (c % 4) != 3;
                    2: out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= (c % 8) > 4;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            bytes_checked++;
            if (pending_beats.size() == 0) begin
                errors++;
                if (mismatches < 10) begin
                    $display("ERROR: unexpected link byte %02h run_end %0b frame_end %0b ovf %0b",
                             out_if.out_byte, out_if.run_end, out_if.frame_end,
                             out_if.overflow);
                end
                mismatches++;
            end else begin
                head_beat = pending_beats.pop_front();
                if (out_if.out_byte !== head_beat.out_byte
                        || out_if.run_end !== head_beat.run_end
                        || out_if.frame_end !== head_beat.frame_end
                        || out_if.overflow !== head_beat.overflow) begin
                    errors++;
                    if (mismatches < 10) begin
                        $display("ERROR: link byte %0d exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                 bytes_checked, head_beat.out_byte, head_beat.run_end,
                                 head_beat.frame_end, head_beat.overflow,
                                 out_if.out_byte, out_if.run_end, out_if.frame_end,
                                 out_if.overflow);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_wdata         <= '0;
        in_if.valid         <= 1'b0;
        in_if.data_byte     <= 8'h00;
        in_if.escape_enable <= 1'b0;
        in_if.last          <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_byte_packets();
        test_escaping();
        test_overflow();
        test_tiny_limits();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Covered %0d payload beats in %0d packets under %0d length settings.",
                 items_sent, packets_sent, settings_used);
        $display("Checked %0d link bytes: %0d closed frames, %0d overflow results, %0d errors.",
                 bytes_checked, frames_closed, overflow_beats, errors);
        if (errors == 0) begin
            $display("** remote_debug_packet_framer_core: PASSED **");
        end else begin
            $display("** remote_debug_packet_framer_core: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/rdpf_pkg.sv
src/rdpf_item_if.sv
src/rdpf_beat_if.sv
src/rdpf_queue.sv
src/rdpf_front.sv
src/rdpf_back.sv
src/remote_debug_packet_framer_core.sv
test/remote_debug_packet_framer_core_test.sv
